// File: rtl/qdasc_pkg.sv
// ----------------------------------------------------------------------------
// qdasc_pkg: shared types and constants for the quotient to ascii block
// Holds the controller/datapath command and status structs, the output
// character select codes and the fixed text constants.
// ----------------------------------------------------------------------------
package qdasc_pkg;

   // width of the scaled numerator (32-bit value times 100 fits in 39 bits)
   localparam int unsigned QUOT_BITS = 39;
   // bcd digits needed for a quotient below 10^12
   localparam int unsigned NUM_BCD   = 12;
   localparam int unsigned BCD_BITS  = 4 * NUM_BCD;
   // work width for remainder times ten
   localparam int unsigned FRAC_BITS = 36;
   // longest text of one item
   localparam int unsigned MAX_OUT   = 7;
   // length of the error text
   localparam int unsigned ERR_LEN   = 5;

   // ascii codes
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] CHAR_PCT  = 8'h25;

   // output character select codes
   localparam logic [2:0] SEL_DIGIT = 3'd0;
   localparam logic [2:0] SEL_FRAC  = 3'd1;
   localparam logic [2:0] SEL_DOT   = 3'd2;
   localparam logic [2:0] SEL_PCT   = 3'd3;
   localparam logic [2:0] SEL_ERR   = 3'd4;

   // commands from controller to datapath
   typedef struct packed {
      logic       load;
      logic       div_step;
      logic       norm_step;
      logic       int_shift;
      logic       mul10;
      logic       fdiv_step;
      logic [1:0] fdiv_sh;
      logic       out_load;
      logic [2:0] out_sel;
      logic       out_last;
      logic [2:0] err_idx;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic div_zero;
      logic percent;
      logic top_zero;
   } stat_type;

   // letters of the error text
   function automatic logic [7:0] err_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h45;  // E
         3'd1:    c = 8'h52;  // R
         3'd2:    c = 8'h52;  // R
         3'd3:    c = 8'h4F;  // O
         3'd4:    c = 8'h52;  // R
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// File: rtl/qdasc_dp.sv
// ----------------------------------------------------------------------------
// qdasc_dp: datapath of the quotient to ascii block
// Restoring divider with on-the-fly binary to bcd conversion, digit
// normalizer, remainder-times-ten digit divider and the output word register.
// ----------------------------------------------------------------------------
module qdasc_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [31:0]          req_dividend,
   input  logic [31:0]          req_divisor,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data,
   input  qdasc_pkg::cmd_type   cmd,
   output qdasc_pkg::stat_type  stat,
   output logic [7:0]           rsp_out_char,
   output logic                 rsp_is_last
);

   logic                                percent_mode_ff;
   logic [qdasc_pkg::QUOT_BITS-1:0]     num_ff;
   logic [31:0]                         divisor_ff;
   logic [31:0]                         rem_ff;
   logic [qdasc_pkg::BCD_BITS-1:0]      bcd_ff;
   logic [qdasc_pkg::FRAC_BITS-1:0]     frac_ff;
   logic [3:0]                          fdig_ff;
   logic [7:0]                          out_char_ff;
   logic                                out_last_ff;

   logic [qdasc_pkg::QUOT_BITS-1:0]     num_in;
   logic [qdasc_pkg::QUOT_BITS-1:0]     din_ext;
   logic [33:0]                         trial;
   logic                                qbit;
   logic [31:0]                         rem_div;
   logic [qdasc_pkg::BCD_BITS-1:0]      bcd_adj;
   logic [qdasc_pkg::FRAC_BITS-1:0]     dsh;
   logic [qdasc_pkg::FRAC_BITS-1:0]     fsub;
   logic                                fge;
   logic [qdasc_pkg::FRAC_BITS-1:0]     frac_next;
   logic [qdasc_pkg::FRAC_BITS-1:0]     rem_x10;
   logic [7:0]                          char_in;

   // percent mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         percent_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         percent_mode_ff <= csr_wr_data;
      end
   end

   // numerator scaling: times 100 as shifts and adds in percent mode, else unchanged
   always_comb begin
      din_ext = {{(qdasc_pkg::QUOT_BITS-32){1'b0}}, req_dividend};
      if (percent_mode_ff) begin
         num_in = (din_ext << 6) + (din_ext << 5) + (din_ext << 2);
      end else begin
         num_in = din_ext;
      end
   end

   // one restoring division step
   always_comb begin
      trial   = {1'b0, rem_ff, num_ff[qdasc_pkg::QUOT_BITS-1]} - {2'b00, divisor_ff};
      qbit    = ~trial[33];
      rem_div = qbit ? trial[31:0] : {rem_ff[30:0], num_ff[qdasc_pkg::QUOT_BITS-1]};
   end

   // double dabble add-3 correction on every bcd digit
   always_comb begin
      for (int i = 0; i < qdasc_pkg::NUM_BCD; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // fractional digit: remainder times ten, then four compare and subtract steps
   always_comb begin
      rem_x10   = ({4'b0000, rem_ff} << 3) + ({4'b0000, rem_ff} << 1);
      dsh       = {4'b0000, divisor_ff} << cmd.fdiv_sh;
      fge       = (frac_ff >= dsh);
      fsub      = frac_ff - dsh;
      frac_next = fge ? fsub : frac_ff;
   end

   // divider and digit registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         num_ff     <= num_in;
         divisor_ff <= req_divisor;
         rem_ff     <= '0;
         bcd_ff     <= '0;
      end else if (cmd.div_step) begin
         num_ff <= num_ff << 1;
         rem_ff <= rem_div;
         bcd_ff <= {bcd_adj[qdasc_pkg::BCD_BITS-2:0], qbit};
      end else if (cmd.norm_step || cmd.int_shift) begin
         bcd_ff <= bcd_ff << 4;
      end else if (cmd.mul10) begin
         frac_ff <= rem_x10;
      end else if (cmd.fdiv_step) begin
         frac_ff <= frac_next;
         fdig_ff <= {fdig_ff[2:0], fge};
         if (cmd.fdiv_sh == 2'd0) begin
            rem_ff <= frac_next[31:0];
         end
      end
   end

   // output character select
   always_comb begin
      unique case (cmd.out_sel)
         qdasc_pkg::SEL_DIGIT: char_in = qdasc_pkg::CHAR_ZERO +
                                         {4'h0, bcd_ff[qdasc_pkg::BCD_BITS-1 -: 4]};
         qdasc_pkg::SEL_FRAC:  char_in = qdasc_pkg::CHAR_ZERO + {4'h0, fdig_ff};
         qdasc_pkg::SEL_DOT:   char_in = qdasc_pkg::CHAR_DOT;
         qdasc_pkg::SEL_PCT:   char_in = qdasc_pkg::CHAR_PCT;
         qdasc_pkg::SEL_ERR:   char_in = qdasc_pkg::err_char(cmd.err_idx);
         default:              char_in = 8'h00;
      endcase
   end

   // output word register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_char_ff <= char_in;
         out_last_ff <= cmd.out_last;
      end
   end

   assign rsp_out_char  = out_char_ff;
   assign rsp_is_last   = out_last_ff;

   // status back to the controller
   assign stat.div_zero = (req_divisor == 32'd0);
   assign stat.percent  = percent_mode_ff;
   assign stat.top_zero = (bcd_ff[qdasc_pkg::BCD_BITS-1 -: 4] == 4'h0);

endmodule

// File: rtl/qdasc_ctrl.sv
// ----------------------------------------------------------------------------
// qdasc_ctrl: controller of the quotient to ascii block
// Sequences division, digit normalization, integer digits, dot, fractional
// digits, percent sign or error text, and owns both channels' handshake.
// ----------------------------------------------------------------------------
module qdasc_ctrl #(
   parameter int SIG_DIGITS = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  qdasc_pkg::stat_type  stat,
   output qdasc_pkg::cmd_type   cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DIV  = 4'd1;
   localparam logic [3:0] S_NORM = 4'd2;
   localparam logic [3:0] S_INT  = 4'd3;
   localparam logic [3:0] S_DOT  = 4'd4;
   localparam logic [3:0] S_MUL  = 4'd5;
   localparam logic [3:0] S_FDIV = 4'd6;
   localparam logic [3:0] S_FRAC = 4'd7;
   localparam logic [3:0] S_PCT  = 4'd8;
   localparam logic [3:0] S_ERR  = 4'd9;

   localparam logic [3:0] SIG_W       = 4'(SIG_DIGITS);
   localparam logic [5:0] DIV_LAST    = 6'(qdasc_pkg::QUOT_BITS - 1);
   localparam logic [3:0] ND_START    = 4'(qdasc_pkg::NUM_BCD);
   localparam logic [2:0] CNT_LAST    = 3'(qdasc_pkg::MAX_OUT - 1);
   localparam logic [2:0] PCT_DOT_MAX = 3'(qdasc_pkg::MAX_OUT - 3);
   localparam logic [2:0] ERR_LAST    = 3'(qdasc_pkg::ERR_LEN - 1);

   logic [3:0] state_ff, state_in;
   logic [5:0] step_ff, step_in;
   logic [3:0] nd_ff, nd_in;
   logic [3:0] int_rem_ff, int_rem_in;
   logic [3:0] left_ff, left_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       slot_free;
   logic       cnt_at_max;
   logic [3:0] take_w;
   logic       last_w;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         nd_ff        <= '0;
         int_rem_ff   <= '0;
         left_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         nd_ff        <= nd_in;
         int_rem_ff   <= int_rem_in;
         left_ff      <= left_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      nd_in      = nd_ff;
      int_rem_in = int_rem_ff;
      left_in    = left_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      last_w     = 1'b0;
      slot_free  = ~rsp_valid_ff | ~rsp_stall;
      cnt_at_max = (cnt_ff == CNT_LAST);
      take_w     = (nd_ff < SIG_W) ? nd_ff : SIG_W;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               cnt_in   = '0;
               state_in = stat.div_zero ? S_ERR : S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 6'd1;
            if (step_ff == DIV_LAST) begin
               nd_in    = ND_START;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            // drop leading zero digits, keep at least one
            if (stat.top_zero && nd_ff != 4'd1) begin
               cmd.norm_step = 1'b1;
               nd_in         = nd_ff - 4'd1;
            end else begin
               int_rem_in = take_w;
               left_in    = SIG_W - take_w;
               state_in   = S_INT;
            end
         end
         S_INT: begin
            if (slot_free) begin
               last_w        = (int_rem_ff == 4'd1 && left_ff == 4'd0) || cnt_at_max;
               cmd.out_load  = 1'b1;
               cmd.out_sel   = qdasc_pkg::SEL_DIGIT;
               cmd.out_last  = last_w;
               cmd.int_shift = 1'b1;
               int_rem_in    = int_rem_ff - 4'd1;
               cnt_in        = cnt_ff + 3'd1;
               if (last_w) begin
                  state_in = S_IDLE;
               end else if (int_rem_ff == 4'd1) begin
                  state_in = S_DOT;
               end
            end
         end
         S_DOT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               cnt_in       = cnt_ff + 3'd1;
               if (stat.percent) begin
                  // room for dot, one fractional digit and the percent sign
                  if (cnt_ff <= PCT_DOT_MAX) begin
                     cmd.out_sel = qdasc_pkg::SEL_DOT;
                     state_in    = S_MUL;
                  end else begin
                     cmd.out_sel  = qdasc_pkg::SEL_PCT;
                     cmd.out_last = 1'b1;
                     state_in     = S_IDLE;
                  end
               end else begin
                  cmd.out_sel  = qdasc_pkg::SEL_DOT;
                  cmd.out_last = cnt_at_max;
                  state_in     = cnt_at_max ? S_IDLE : S_MUL;
               end
            end
         end
         S_MUL: begin
            cmd.mul10 = 1'b1;
            step_in   = '0;
            state_in  = S_FDIV;
         end
         S_FDIV: begin
            cmd.fdiv_step = 1'b1;
            cmd.fdiv_sh   = ~step_ff[1:0];
            step_in       = step_ff + 6'd1;
            if (step_ff[1:0] == 2'd3) begin
               state_in = S_FRAC;
            end
         end
         S_FRAC: begin
            if (slot_free) begin
               if (stat.percent) begin
                  last_w = cnt_at_max;
               end else begin
                  last_w = (left_ff == 4'd1) || cnt_at_max;
               end
               cmd.out_load = 1'b1;
               cmd.out_sel  = qdasc_pkg::SEL_FRAC;
               cmd.out_last = last_w;
               left_in      = left_ff - 4'd1;
               cnt_in       = cnt_ff + 3'd1;
               if (last_w) begin
                  state_in = S_IDLE;
               end else if (stat.percent) begin
                  state_in = S_PCT;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_PCT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = qdasc_pkg::SEL_PCT;
               cmd.out_last = 1'b1;
               cnt_in       = cnt_ff + 3'd1;
               state_in     = S_IDLE;
            end
         end
         S_ERR: begin
            if (slot_free) begin
               last_w       = (step_ff[2:0] == ERR_LAST) || cnt_at_max;
               cmd.out_load = 1'b1;
               cmd.out_sel  = qdasc_pkg::SEL_ERR;
               cmd.err_idx  = step_ff[2:0];
               cmd.out_last = last_w;
               step_in      = step_ff + 6'd1;
               cnt_in       = cnt_ff + 3'd1;
               if (last_w) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output word valid
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/quotient_to_decimal_ascii_top.sv
// For a zero divisor the error text follows the accept with no division; else
// the first word follows the restoring divider and the leading-zero shifts.
// Each fractional digit takes a times-ten step, 4 subtract steps and one
// output word; one item is handled at a time, and any output word may wait
// on rsp_stall.
// Reset is synchronous, active high: clears the sequencer, output valid and
// percent mode.
// ----------------------------------------------------------------------------
// quotient_to_decimal_ascii_top: quotient of two 32-bit numbers as ascii text
// Emits up to SIG_DIGITS significant decimal digits, one character per word,
// with a last marker; optional percent rendering and an error text on zero.
// ----------------------------------------------------------------------------
module quotient_to_decimal_ascii_top #(
   parameter int SIG_DIGITS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_dividend,
   input  logic [31:0] req_divisor,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_is_last,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   qdasc_pkg::cmd_type  cmd;
   qdasc_pkg::stat_type stat;

   // sequencer and handshake
   qdasc_ctrl #(
      .SIG_DIGITS (SIG_DIGITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // divider, digit logic and output register
   qdasc_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_dividend (req_dividend),
      .req_divisor  (req_divisor),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_out_char (rsp_out_char),
      .rsp_is_last  (rsp_is_last)
   );

endmodule
